FILE: hdl/bqd_pkg.sv
// Shared types and constants of the Q14 direct-form-I biquad filter.
`default_nettype none

package bqd_pkg;

	// Field and datapath widths
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned RESULT_W   = 18;
	localparam int unsigned COEF_W     = 16;
	localparam int unsigned ACC_W      = 32;
	localparam int unsigned Q_SHIFT    = 14;
	localparam int unsigned OUT_DATA_W = 24;

	// Configuration port layout
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_IDX_W  = 3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

	// Reset coefficients: Butterworth low-pass
	localparam logic signed [COEF_W-1:0] B0_RESET = 16'sd1105;
	localparam logic signed [COEF_W-1:0] B1_RESET = 16'sd2210;
	localparam logic signed [COEF_W-1:0] B2_RESET = 16'sd1105;
	localparam logic signed [COEF_W-1:0] A1_RESET = 16'sd18727;
	localparam logic signed [COEF_W-1:0] A2_RESET = -16'sd6763;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [RESULT_W-1:0] result_t;
	typedef logic signed [COEF_W-1:0]   coef_val_t;

	// Filter coefficient set
	typedef struct packed {
		coef_val_t b0;
		coef_val_t b1;
		coef_val_t b2;
		coef_val_t a1;
		coef_val_t a2;
	} coef_t;

	// Delay line of past inputs and outputs
	typedef struct packed {
		sample_t in_1;
		sample_t in_2;
		result_t out_1;
		result_t out_2;
	} hist_t;

endpackage

`default_nettype wire

FILE: hdl/bqd_mac.sv
// Five-tap multiply and saturating accumulate of the biquad, combinational.
`default_nettype none

module bqd_mac (
	input  wire bqd_pkg::coef_t   coef,
	input  wire bqd_pkg::hist_t   hist,
	input  wire bqd_pkg::sample_t x,
	output bqd_pkg::result_t      y
);

	localparam int unsigned AW = bqd_pkg::ACC_W;
	localparam int unsigned PW = bqd_pkg::COEF_W + bqd_pkg::RESULT_W;

	// Add two accumulator words, clamping to the signed range
	function automatic logic signed [AW-1:0] sat_add(
		input logic signed [AW-1:0] a,
		input logic signed [AW-1:0] b
	);
		logic signed [AW:0] s;
		logic signed [AW-1:0] r;
		s = {a[AW-1], a} + {b[AW-1], b};
		if (s[AW] != s[AW-1]) begin
			r = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			r = s[AW-1:0];
		end
		return r;
	endfunction

	logic signed [AW-1:0] p_b0;
	logic signed [AW-1:0] p_b1;
	logic signed [AW-1:0] p_b2;
	logic signed [PW-1:0] p_a1_full;
	logic signed [PW-1:0] p_a2_full;
	logic signed [AW-1:0] acc_1;
	logic signed [AW-1:0] acc_2;
	logic signed [AW-1:0] acc_3;
	logic signed [AW-1:0] acc_4;

	// Form the products; the feedback ones wrap to the accumulator width
	always_comb begin
		p_b0      = AW'(coef.b0) * AW'(x);
		p_b1      = AW'(coef.b1) * AW'(hist.in_1);
		p_b2      = AW'(coef.b2) * AW'(hist.in_2);
		p_a1_full = PW'(coef.a1) * PW'(hist.out_1);
		p_a2_full = PW'(coef.a2) * PW'(hist.out_2);
	end

	// Accumulate in fixed order, saturating at each add
	always_comb begin
		acc_1 = sat_add(p_b0, p_b1);
		acc_2 = sat_add(acc_1, p_b2);
		acc_3 = sat_add(acc_2, $signed(p_a1_full[AW-1:0]));
		acc_4 = sat_add(acc_3, $signed(p_a2_full[AW-1:0]));
	end

	// Drop the Q14 fraction with an arithmetic (flooring) shift
	assign y = $signed(acc_4[AW-1:bqd_pkg::Q_SHIFT]);

endmodule

`default_nettype wire

FILE: hdl/biquad_iir_saturating_q14.sv
// Top level of the Q14 direct-form-I biquad filter with stream and APB ports.
`default_nettype none

// One sample in, one sample out, at one sample per clock when not stalled. A
// sample taken on the slave stream is held in an input register; when the
// output register is free or being taken, the five products and four
// saturating adds, formed in one pass, are written to the output register
// together with the delay line, and the result is offered on the master
// stream from that register. The feedback through the previous outputs
// closes this loop through the delay line register. The input side stalls
// only when both the input and output registers hold samples and the master
// stream is not taking. Coefficients are Q14, written over APB at byte
// address 4*i (b0, b1, b2, a1, a2); write them only while the filter is idle.
module biquad_iir_saturating_q14 (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Slave stream
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [bqd_pkg::SAMPLE_W-1:0]         s_tdata,   // [15:0] sample_in
	// Master stream
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [bqd_pkg::OUT_DATA_W-1:0]      m_tdata,   // [17:0] sample_out, [23:18] zero
	// Configuration
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire [bqd_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire [bqd_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [bqd_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int unsigned PAD_W = bqd_pkg::OUT_DATA_W - bqd_pkg::RESULT_W;
	localparam int unsigned RD_PAD_W = bqd_pkg::APB_DATA_W - bqd_pkg::COEF_W;

	bqd_pkg::coef_t   coef_q;
	bqd_pkg::hist_t   hist_q;
	bqd_pkg::sample_t x_s1;
	logic             valid_s1;
	bqd_pkg::result_t y_q;
	logic             out_valid_q;
	bqd_pkg::result_t y_next;
	logic             advance;
	logic             cfg_wr;
	logic [bqd_pkg::REG_IDX_W-1:0] reg_idx;
	logic [bqd_pkg::COEF_W-1:0]    rd_val;

	// Configuration access
	assign pready  = 1'b1;
	assign reg_idx = paddr[bqd_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= bqd_pkg::B0_RESET;
			coef_q.b1 <= bqd_pkg::B1_RESET;
			coef_q.b2 <= bqd_pkg::B2_RESET;
			coef_q.a1 <= bqd_pkg::A1_RESET;
			coef_q.a2 <= bqd_pkg::A2_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bqd_pkg::REG_B0: coef_q.b0 <= pwdata[bqd_pkg::COEF_W-1:0];
				bqd_pkg::REG_B1: coef_q.b1 <= pwdata[bqd_pkg::COEF_W-1:0];
				bqd_pkg::REG_B2: coef_q.b2 <= pwdata[bqd_pkg::COEF_W-1:0];
				bqd_pkg::REG_A1: coef_q.a1 <= pwdata[bqd_pkg::COEF_W-1:0];
				bqd_pkg::REG_A2: coef_q.a2 <= pwdata[bqd_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the selected coefficient
	always_comb begin
		unique case (reg_idx)
			bqd_pkg::REG_B0: rd_val = coef_q.b0;
			bqd_pkg::REG_B1: rd_val = coef_q.b1;
			bqd_pkg::REG_B2: rd_val = coef_q.b2;
			bqd_pkg::REG_A1: rd_val = coef_q.a1;
			bqd_pkg::REG_A2: rd_val = coef_q.a2;
			default:         rd_val = '0;
		endcase
	end
	assign prdata = {{RD_PAD_W{1'b0}}, rd_val};

	// Handshake: the input stage advances whenever it holds a sample and the output register is empty or being taken
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_s1 <= s_tdata;
		end
	end

	bqd_mac u_mac (
		.coef (coef_q),
		.hist (hist_q),
		.x    (x_s1),
		.y    (y_next)
	);

	// Output register and delay line advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hist_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q  <= 1'b1;
				hist_q.in_1  <= x_s1;
				hist_q.in_2  <= hist_q.in_1;
				hist_q.out_1 <= y_next;
				hist_q.out_2 <= hist_q.out_1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			y_q <= y_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, y_q};

	// The delay line carries the result just written
	a_out_hist: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (hist_q.out_1 == y_q))
		else $error("delay line out_1 differs from the emitted result");

	// Past inputs shift along on each advance
	a_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (hist_q.in_1 == $past(x_s1)) && (hist_q.in_2 == $past(hist_q.in_1)))
		else $error("input delay line did not shift");

	// Past outputs shift along on each advance
	a_out_shift: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (hist_q.out_2 == $past(hist_q.out_1)))
		else $error("output delay line did not shift");

	// Input stalls only when both registers are full and the output is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
